[rtl/core/letterbox_nearest_scale_address_defines.svh]
// Assertion macros for the letterbox nearest-neighbour scale address block.
// The including module must have clk and arst_n in scope; no other dependencies.
`ifndef LETTERBOX_NEAREST_SCALE_ADDRESS_DEFINES_SVH
`define LETTERBOX_NEAREST_SCALE_ADDRESS_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LNSA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LNSA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/lnsa_pkg.sv]
// Shared constants, payload types and control types of the letterbox scale address block.
// Used by lnsa_geom and letterbox_nearest_scale_address; depends on nothing else.
package lnsa_pkg;

	// Display image area.
	localparam int OUT_WIDTH  = 480;
	localparam int OUT_HEIGHT = 360;

	// Field widths fixed by the interface.
	localparam int X_BITS     = 9;
	localparam int Y_BITS     = 9;
	localparam int SRC_BITS   = 15;
	localparam int COORD_BITS = 14;
	localparam int INDEX_BITS = 28;
	localparam int SRC_MAX    = 16384;

	// Fitted size widths follow from the area.
	localparam int DW_BITS   = $clog2(OUT_WIDTH + 1);
	localparam int DH_BITS   = $clog2(OUT_HEIGHT + 1);
	localparam int CMPX_BITS = ((X_BITS > DW_BITS) ? X_BITS : DW_BITS) + 1;
	localparam int CMPY_BITS = ((Y_BITS > DH_BITS) ? Y_BITS : DH_BITS) + 1;
	localparam int PX_BITS   = DW_BITS + SRC_BITS;
	localparam int PY_BITS   = DH_BITS + SRC_BITS;
	localparam int PROD_BITS = COORD_BITS + SRC_BITS;

	// Pixel divider: quotient bits retired per pipeline stage.
	localparam int DIV_PER_STAGE = 2;
	localparam int DIV_STAGES    = COORD_BITS / DIV_PER_STAGE;

	// Stage positions in the pixel pipeline.
	localparam int ST_DIV0   = 2;
	localparam int ST_CLAMP  = ST_DIV0 + DIV_STAGES;
	localparam int ST_OUT    = ST_CLAMP + 1;
	localparam int NSTAGE    = ST_OUT + 1;

	// Geometry divider, one quotient bit per cycle.
	localparam int GDIV_BITS = SRC_BITS + ((DW_BITS > DH_BITS) ? DW_BITS : DH_BITS);
	localparam int GCNT_BITS = $clog2(GDIV_BITS);

	typedef logic [SRC_BITS-1:0]   size_t;
	typedef logic [DW_BITS-1:0]    dwid_t;
	typedef logic [DH_BITS-1:0]    dhid_t;
	typedef logic [CMPX_BITS-1:0]  xcmp_t;
	typedef logic [CMPY_BITS-1:0]  ycmp_t;
	typedef logic [PX_BITS-1:0]    px_t;
	typedef logic [PY_BITS-1:0]    py_t;
	typedef logic [PROD_BITS-1:0]  prod_t;
	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [INDEX_BITS-1:0] index_t;
	typedef logic [GDIV_BITS-1:0]  gdiv_t;
	typedef logic [GCNT_BITS-1:0]  gcnt_t;

	typedef enum logic [0:0] {
		REG_SRC_WIDTH  = 1'b0,
		REG_SRC_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [X_BITS-1:0] out_x;
		logic [Y_BITS-1:0] out_y;
	} pix_t;

	typedef struct packed {
		logic                  in_image;
		logic [COORD_BITS-1:0] src_col;
		logic [COORD_BITS-1:0] src_row;
		logic [INDEX_BITS-1:0] src_index;
	} res_t;

	// Fit geometry handed from the geometry unit to the pixel pipeline.
	typedef struct packed {
		size_t nw;
		size_t nh;
		dwid_t fit_w;
		dhid_t fit_h;
		dwid_t off_x;
		dhid_t off_y;
	} geom_t;

	typedef enum logic [2:0] {
		GS_LOAD_H,
		GS_DIV_H,
		GS_CHECK,
		GS_LOAD_W,
		GS_DIV_W,
		GS_SET_W,
		GS_FINISH,
		GS_IDLE
	} gs_t;

endpackage

[rtl/core/lnsa_geom.sv]
// Geometry unit: source size registers and the fitted size and offsets derived from them.
// Depends on lnsa_pkg and the assertion macros in letterbox_nearest_scale_address_defines.svh.
`include "letterbox_nearest_scale_address_defines.svh"

module lnsa_geom (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  lnsa_pkg::cfg_reg_t             cfg_index,
	input  logic [lnsa_pkg::SRC_BITS-1:0]  cfg_data,
	output lnsa_pkg::geom_t                geom,
	output logic                           busy
);

	typedef struct packed {
		logic load;
		logic by_h;
		logic step;
		logic take_h;
		logic take_w;
		logic offsets;
	} gctl_t;

	function automatic lnsa_pkg::size_t eff_size(input lnsa_pkg::size_t v);
		lnsa_pkg::size_t r;
		if (v == '0) begin
			r = lnsa_pkg::size_t'(1);
		end else if (v > lnsa_pkg::size_t'(lnsa_pkg::SRC_MAX)) begin
			r = lnsa_pkg::size_t'(lnsa_pkg::SRC_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

	lnsa_pkg::size_t             src_width_q;
	lnsa_pkg::size_t             src_height_q;
	lnsa_pkg::size_t             nw;
	lnsa_pkg::size_t             nh;
	lnsa_pkg::gs_t               state_q;
	lnsa_pkg::gs_t               state_d;
	gctl_t                       ctl;
	lnsa_pkg::size_t             rem_q;
	lnsa_pkg::gdiv_t             quo_q;
	lnsa_pkg::gcnt_t             cnt_q;
	lnsa_pkg::size_t             den;
	logic [lnsa_pkg::SRC_BITS:0] trial;
	logic                        fits;
	logic                        cnt_last;
	logic                        too_tall;
	lnsa_pkg::dwid_t             dw_q;
	lnsa_pkg::dhid_t             dh_q;
	lnsa_pkg::dwid_t             ox_q;
	lnsa_pkg::dhid_t             oy_q;

	assign nw = eff_size(src_width_q);
	assign nh = eff_size(src_height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= lnsa_pkg::size_t'(1);
			src_height_q <= lnsa_pkg::size_t'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				lnsa_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				lnsa_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data;
				default:                  src_width_q  <= src_width_q;
			endcase
		end
	end

	// Restoring division, one bit per cycle, of the scaled size by the other size.
	assign den      = ctl.by_h ? nh : nw;
	assign trial    = {rem_q, quo_q[lnsa_pkg::GDIV_BITS-1]};
	assign fits     = trial >= {1'b0, den};
	assign cnt_last = cnt_q == lnsa_pkg::gcnt_t'(lnsa_pkg::GDIV_BITS - 1);
	assign too_tall = quo_q > lnsa_pkg::gdiv_t'(lnsa_pkg::OUT_HEIGHT);

	always_comb begin
		state_d = state_q;
		priority if (cfg_we) begin
			state_d = lnsa_pkg::GS_LOAD_H;
		end else begin
			unique case (state_q)
				lnsa_pkg::GS_LOAD_H: state_d = lnsa_pkg::GS_DIV_H;
				lnsa_pkg::GS_DIV_H:  state_d = cnt_last ? lnsa_pkg::GS_CHECK : lnsa_pkg::GS_DIV_H;
				lnsa_pkg::GS_CHECK:  state_d = too_tall ? lnsa_pkg::GS_LOAD_W : lnsa_pkg::GS_FINISH;
				lnsa_pkg::GS_LOAD_W: state_d = lnsa_pkg::GS_DIV_W;
				lnsa_pkg::GS_DIV_W:  state_d = cnt_last ? lnsa_pkg::GS_SET_W : lnsa_pkg::GS_DIV_W;
				lnsa_pkg::GS_SET_W:  state_d = lnsa_pkg::GS_FINISH;
				lnsa_pkg::GS_FINISH: state_d = lnsa_pkg::GS_IDLE;
				lnsa_pkg::GS_IDLE:   state_d = lnsa_pkg::GS_IDLE;
				default:             state_d = lnsa_pkg::GS_LOAD_H;
			endcase
		end
	end

	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		unique case (state_q)
			lnsa_pkg::GS_LOAD_H: ctl.load = 1'b1;
			lnsa_pkg::GS_DIV_H:  ctl.step = 1'b1;
			lnsa_pkg::GS_CHECK:  ctl.take_h = 1'b1;
			lnsa_pkg::GS_LOAD_W: begin
				ctl.load = 1'b1;
				ctl.by_h = 1'b1;
			end
			lnsa_pkg::GS_DIV_W: begin
				ctl.step = 1'b1;
				ctl.by_h = 1'b1;
			end
			lnsa_pkg::GS_SET_W:  ctl.take_w = 1'b1;
			lnsa_pkg::GS_FINISH: ctl.offsets = 1'b1;
			lnsa_pkg::GS_IDLE:   busy = 1'b0;
			default:             busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lnsa_pkg::GS_LOAD_H;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				cnt_q <= '0;
			end else if (ctl.step) begin
				cnt_q <= cnt_q + lnsa_pkg::gcnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= '0;
			quo_q <= ctl.by_h
				? lnsa_pkg::gdiv_t'(nw) * lnsa_pkg::gdiv_t'(lnsa_pkg::OUT_HEIGHT)
				: lnsa_pkg::gdiv_t'(nh) * lnsa_pkg::gdiv_t'(lnsa_pkg::OUT_WIDTH);
		end else if (ctl.step) begin
			rem_q <= fits ? lnsa_pkg::size_t'(trial - {1'b0, den})
				: trial[lnsa_pkg::SRC_BITS-1:0];
			quo_q <= {quo_q[lnsa_pkg::GDIV_BITS-2:0], fits};
		end
	end

	// The fitted rectangle always fills at least one side of the area.
	always_ff @(posedge clk) begin
		if (ctl.take_h) begin
			if (too_tall) begin
				dh_q <= lnsa_pkg::dhid_t'(lnsa_pkg::OUT_HEIGHT);
			end else begin
				dw_q <= lnsa_pkg::dwid_t'(lnsa_pkg::OUT_WIDTH);
				dh_q <= (quo_q == '0) ? lnsa_pkg::dhid_t'(1) : quo_q[lnsa_pkg::DH_BITS-1:0];
			end
		end
		if (ctl.take_w) begin
			if (quo_q == '0) begin
				dw_q <= lnsa_pkg::dwid_t'(1);
			end else if (quo_q > lnsa_pkg::gdiv_t'(lnsa_pkg::OUT_WIDTH)) begin
				dw_q <= lnsa_pkg::dwid_t'(lnsa_pkg::OUT_WIDTH);
			end else begin
				dw_q <= quo_q[lnsa_pkg::DW_BITS-1:0];
			end
		end
		if (ctl.offsets) begin
			ox_q <= (lnsa_pkg::dwid_t'(lnsa_pkg::OUT_WIDTH) - dw_q) >> 1;
			oy_q <= (lnsa_pkg::dhid_t'(lnsa_pkg::OUT_HEIGHT) - dh_q) >> 1;
		end
	end

	assign geom.nw    = nw;
	assign geom.nh    = nh;
	assign geom.fit_w = dw_q;
	assign geom.fit_h = dh_q;
	assign geom.off_x = ox_q;
	assign geom.off_y = oy_q;

	`LNSA_ASSERT_NEXT(a_cfg_restarts_fit, cfg_we, busy, "configuration write did not restart the fit")
	`LNSA_ASSERT_NOW(a_fit_fills_side, !busy, (dw_q == lnsa_pkg::dwid_t'(lnsa_pkg::OUT_WIDTH)) || (dh_q == lnsa_pkg::dhid_t'(lnsa_pkg::OUT_HEIGHT)), "fitted rectangle fills neither side")
	`LNSA_ASSERT_NOW(a_fit_nonzero, !busy, (dw_q != '0) && (dh_q != '0), "fitted rectangle has a zero side")

endmodule

[rtl/core/letterbox_nearest_scale_address.sv]
// Top level of the letterbox nearest-neighbour scale address block: pixel pipeline.
// Depends on lnsa_pkg, lnsa_geom and letterbox_nearest_scale_address_defines.svh.
`include "letterbox_nearest_scale_address_defines.svh"

// Maps each display coordinate beat on pix to one result beat on res: whether the
// pixel lies inside the centred, aspect-preserving fit of the source, and if so the
// source column, row and linear index it samples. Both channels use valid/stall; a
// beat moves at a rising edge with valid high and stall low.
// The source size is set through the write port (cfg_we, cfg_index, cfg_data). Each
// write, and reset, starts the geometry unit: a one-bit-per-cycle divider that finds
// the fitted size and offsets, with a second division when the fit is limited by height.
// pix_stall is held high meanwhile and during the cycle of a write.
// Reset clears all valid bits, sets both source sizes to 1 and starts that pass.
// Thereafter one beat is taken every cycle while pix_stall is low. Each accepted
// beat passes through the offset, multiply, divider, clamp and output stages in
// turn before its result appears with res_valid. The depth is set by the pixel
// divider: two quotient bits per stage over seven stages, after offset and multiply.
// When res_stall is high, the last stage holds its beat; earlier stages keep moving
// into empty slots, so pix_stall rises only once the pipeline is full.
module letterbox_nearest_scale_address (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  lnsa_pkg::pix_t                 pix,
	output logic                           res_valid,
	input  logic                           res_stall,
	output lnsa_pkg::res_t                 res,
	input  logic                           cfg_we,
	input  lnsa_pkg::cfg_reg_t             cfg_index,
	input  logic [lnsa_pkg::SRC_BITS-1:0]  cfg_data
);

	lnsa_pkg::geom_t                 geom;
	logic                            geom_busy;
	logic [lnsa_pkg::NSTAGE-1:0]     stage_vld_q;
	logic [lnsa_pkg::NSTAGE-1:0]     stage_en;
	logic                            pix_take;

	// Offset stage.
	lnsa_pkg::xcmp_t                 x_ext;
	lnsa_pkg::xcmp_t                 ox_ext;
	lnsa_pkg::xcmp_t                 x_end;
	lnsa_pkg::ycmp_t                 y_ext;
	lnsa_pkg::ycmp_t                 oy_ext;
	lnsa_pkg::ycmp_t                 y_end;
	logic                            in_x;
	logic                            in_y;
	logic                            in_s1;
	lnsa_pkg::dwid_t                 ux_s1;
	lnsa_pkg::dhid_t                 uy_s1;

	// Multiply stage.
	logic                            in_s2;
	lnsa_pkg::px_t                   nux_s2;
	lnsa_pkg::py_t                   nuy_s2;

	// Divider stages: element k is pipeline stage 3+k.
	logic                            din_in [lnsa_pkg::DIV_STAGES];
	lnsa_pkg::dwid_t                 din_remx [lnsa_pkg::DIV_STAGES];
	lnsa_pkg::coord_t                din_qx [lnsa_pkg::DIV_STAGES];
	lnsa_pkg::dhid_t                 din_remy [lnsa_pkg::DIV_STAGES];
	lnsa_pkg::coord_t                din_qy [lnsa_pkg::DIV_STAGES];
	lnsa_pkg::dwid_t                 remx_d [lnsa_pkg::DIV_STAGES];
	lnsa_pkg::coord_t                qx_d [lnsa_pkg::DIV_STAGES];
	lnsa_pkg::dhid_t                 remy_d [lnsa_pkg::DIV_STAGES];
	lnsa_pkg::coord_t                qy_d [lnsa_pkg::DIV_STAGES];
	logic                            in_s3 [lnsa_pkg::DIV_STAGES];
	lnsa_pkg::dwid_t                 remx_s3 [lnsa_pkg::DIV_STAGES];
	lnsa_pkg::coord_t                qx_s3 [lnsa_pkg::DIV_STAGES];
	lnsa_pkg::dhid_t                 remy_s3 [lnsa_pkg::DIV_STAGES];
	lnsa_pkg::coord_t                qy_s3 [lnsa_pkg::DIV_STAGES];

	// Clamp and row multiply stage, then the output stage.
	lnsa_pkg::coord_t                qx_f;
	lnsa_pkg::coord_t                qy_f;
	lnsa_pkg::coord_t                sx_d;
	lnsa_pkg::coord_t                sy_d;
	lnsa_pkg::prod_t                 prod_d;
	logic                            in_s10;
	lnsa_pkg::coord_t                sx_s10;
	lnsa_pkg::coord_t                sy_s10;
	lnsa_pkg::index_t                prod_s10;
	lnsa_pkg::res_t                  res_s11;

	lnsa_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.busy      (geom_busy)
	);

	// A stage may load when it is empty or when its own beat moves on.
	always_comb begin
		stage_en[lnsa_pkg::NSTAGE-1] = !stage_vld_q[lnsa_pkg::NSTAGE-1] || !res_stall;
		for (int k = lnsa_pkg::NSTAGE - 2; k >= 0; k--) begin
			stage_en[k] = !stage_vld_q[k] || stage_en[k+1];
		end
	end

	assign pix_stall = !stage_en[0] || geom_busy || cfg_we;
	assign pix_take  = pix_valid && !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				stage_vld_q[0] <= pix_take;
			end
			for (int k = 1; k < lnsa_pkg::NSTAGE; k++) begin
				if (stage_en[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: rectangle test and coordinates relative to the fitted origin.
	always_comb begin
		x_ext  = lnsa_pkg::xcmp_t'(pix.out_x);
		ox_ext = lnsa_pkg::xcmp_t'(geom.off_x);
		x_end  = ox_ext + lnsa_pkg::xcmp_t'(geom.fit_w);
		y_ext  = lnsa_pkg::ycmp_t'(pix.out_y);
		oy_ext = lnsa_pkg::ycmp_t'(geom.off_y);
		y_end  = oy_ext + lnsa_pkg::ycmp_t'(geom.fit_h);
		in_x   = (x_ext >= ox_ext) && (x_ext < x_end);
		in_y   = (y_ext >= oy_ext) && (y_ext < y_end);
	end

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			in_s1 <= in_x && in_y;
			ux_s1 <= lnsa_pkg::dwid_t'(x_ext - ox_ext);
			uy_s1 <= lnsa_pkg::dhid_t'(y_ext - oy_ext);
		end
	end

	// Stage 2: scale the relative coordinates by the source size.
	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			in_s2  <= in_s1;
			nux_s2 <= lnsa_pkg::px_t'(ux_s1) * lnsa_pkg::px_t'(geom.nw);
			nuy_s2 <= lnsa_pkg::py_t'(uy_s1) * lnsa_pkg::py_t'(geom.nh);
		end
	end

	// Divider stages. Inside the rectangle the quotient is below the source size, so it
	// fits in a source coordinate and the upper dividend bits start as the remainder.
	always_comb begin
		din_in[0]   = in_s2;
		din_remx[0] = nux_s2[lnsa_pkg::COORD_BITS +: lnsa_pkg::DW_BITS];
		din_qx[0]   = nux_s2[lnsa_pkg::COORD_BITS-1:0];
		din_remy[0] = nuy_s2[lnsa_pkg::COORD_BITS +: lnsa_pkg::DH_BITS];
		din_qy[0]   = nuy_s2[lnsa_pkg::COORD_BITS-1:0];
		for (int k = 1; k < lnsa_pkg::DIV_STAGES; k++) begin
			din_in[k]   = in_s3[k-1];
			din_remx[k] = remx_s3[k-1];
			din_qx[k]   = qx_s3[k-1];
			din_remy[k] = remy_s3[k-1];
			din_qy[k]   = qy_s3[k-1];
		end
	end

	always_comb begin
		lnsa_pkg::dwid_t            rx;
		lnsa_pkg::coord_t           qx;
		logic [lnsa_pkg::DW_BITS:0] tx;
		lnsa_pkg::dhid_t            ry;
		lnsa_pkg::coord_t           qy;
		logic [lnsa_pkg::DH_BITS:0] ty;
		for (int k = 0; k < lnsa_pkg::DIV_STAGES; k++) begin
			rx = din_remx[k];
			qx = din_qx[k];
			ry = din_remy[k];
			qy = din_qy[k];
			for (int s = 0; s < lnsa_pkg::DIV_PER_STAGE; s++) begin
				tx = {rx, qx[lnsa_pkg::COORD_BITS-1]};
				if (tx >= {1'b0, geom.fit_w}) begin
					rx = lnsa_pkg::dwid_t'(tx - {1'b0, geom.fit_w});
					qx = {qx[lnsa_pkg::COORD_BITS-2:0], 1'b1};
				end else begin
					rx = tx[lnsa_pkg::DW_BITS-1:0];
					qx = {qx[lnsa_pkg::COORD_BITS-2:0], 1'b0};
				end
				ty = {ry, qy[lnsa_pkg::COORD_BITS-1]};
				if (ty >= {1'b0, geom.fit_h}) begin
					ry = lnsa_pkg::dhid_t'(ty - {1'b0, geom.fit_h});
					qy = {qy[lnsa_pkg::COORD_BITS-2:0], 1'b1};
				end else begin
					ry = ty[lnsa_pkg::DH_BITS-1:0];
					qy = {qy[lnsa_pkg::COORD_BITS-2:0], 1'b0};
				end
			end
			remx_d[k] = rx;
			qx_d[k]   = qx;
			remy_d[k] = ry;
			qy_d[k]   = qy;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < lnsa_pkg::DIV_STAGES; k++) begin
			if (stage_en[lnsa_pkg::ST_DIV0 + k]) begin
				in_s3[k]   <= din_in[k];
				remx_s3[k] <= remx_d[k];
				qx_s3[k]   <= qx_d[k];
				remy_s3[k] <= remy_d[k];
				qy_s3[k]   <= qy_d[k];
			end
		end
	end

	// Stage 10: clamp to the last column and row, then start the linear index.
	always_comb begin
		qx_f   = qx_s3[lnsa_pkg::DIV_STAGES-1];
		qy_f   = qy_s3[lnsa_pkg::DIV_STAGES-1];
		sx_d   = ({1'b0, qx_f} >= geom.nw)
			? lnsa_pkg::coord_t'(geom.nw - lnsa_pkg::size_t'(1)) : qx_f;
		sy_d   = ({1'b0, qy_f} >= geom.nh)
			? lnsa_pkg::coord_t'(geom.nh - lnsa_pkg::size_t'(1)) : qy_f;
		prod_d = lnsa_pkg::prod_t'(sy_d) * lnsa_pkg::prod_t'(geom.nw);
	end

	always_ff @(posedge clk) begin
		if (stage_en[lnsa_pkg::ST_CLAMP]) begin
			in_s10   <= in_s3[lnsa_pkg::DIV_STAGES-1];
			sx_s10   <= sx_d;
			sy_s10   <= sy_d;
			prod_s10 <= prod_d[lnsa_pkg::INDEX_BITS-1:0];
		end
	end

	// Stage 11: output register; background pixels report zeros.
	always_ff @(posedge clk) begin
		if (stage_en[lnsa_pkg::ST_OUT]) begin
			res_s11.in_image  <= in_s10;
			res_s11.src_col   <= in_s10 ? sx_s10 : '0;
			res_s11.src_row   <= in_s10 ? sy_s10 : '0;
			res_s11.src_index <= in_s10
				? prod_s10 + lnsa_pkg::index_t'(sx_s10) : '0;
		end
	end

	assign res       = res_s11;
	assign res_valid = stage_vld_q[lnsa_pkg::ST_OUT];

	`LNSA_ASSERT_NEXT(a_accept_fills_s1, pix_valid && !pix_stall, stage_vld_q[0], "accepted beat did not enter the first stage")
	`LNSA_ASSERT_NOW(a_background_zero, res_valid && !res.in_image, (res.src_col == '0) && (res.src_row == '0) && (res.src_index == '0), "background beat carries a source address")

endmodule
